FILE: rtl/core/htfd_pkg.sv
// Shared types, constants and the CRC-8 byte update for the frame decoder.
// No dependencies; used by every module in rtl/core.
package htfd_pkg;

   // Result status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_TEMP_CRC = 2'd1;
   localparam logic [1:0] STATUS_HUM_CRC  = 2'd2;

   // CRC-8, polynomial x^8+x^5+x^4+1, MSB first, no final xor
   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'hFF;

   // Conversion constants
   localparam logic [10:0] TEMP_SCALE  = 11'd1750;
   localparam logic [11:0] TEMP_OFFSET = 12'd450;
   localparam logic [9:0]  HUM_SCALE   = 10'd1000;
   localparam logic [16:0] FULL_SCALE  = 17'd65535;

   // Raw words and status of one complete frame
   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] temp_word;
      logic [15:0] hum_word;
   } frame_item_type;

   function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

FILE: rtl/core/htfd_frame.sv
// Byte tracker: follows the position in the six-byte frame, runs the CRC
// and registers one frame item after the sixth byte. Depends on htfd_pkg.
module htfd_frame (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [7:0]               req_rx_byte,
   input  logic                     req_frame_first,
   output logic                     item_valid,
   input  logic                     item_ready,
   output htfd_pkg::frame_item_type item
);

   typedef enum logic [2:0] {
      POS_TEMP_HIGH = 3'd0,
      POS_TEMP_LOW  = 3'd1,
      POS_TEMP_CRC  = 3'd2,
      POS_HUM_HIGH  = 3'd3,
      POS_HUM_LOW   = 3'd4,
      POS_HUM_CRC   = 3'd5
   } pos_type;

   pos_type     pos_ff, pos_in, pos;
   logic [7:0]  crc_ff, crc_in, crc_base, crc_new;
   logic        temp_ok_ff, temp_ok_in;
   logic [15:0] temp_word_ff, temp_word_in;
   logic [7:0]  hum_high_ff, hum_high_in;
   logic [15:0] hum_word_ff, hum_word_in;
   logic        item_valid_ff, item_valid_in;
   htfd_pkg::frame_item_type item_ff, item_in;
   logic        slot_free, accept, emit;

   assign slot_free = !item_valid_ff || item_ready;
   assign req_stall = !slot_free;
   assign accept    = req_valid && slot_free;

   // realign on the first-byte flag
   assign pos = (req_frame_first || pos_ff > POS_HUM_CRC) ? POS_TEMP_HIGH : pos_ff;
   assign crc_base = (pos == POS_TEMP_HIGH || pos == POS_HUM_HIGH) ? htfd_pkg::CRC_INIT
                                                                    : crc_ff;
   assign crc_new = htfd_pkg::crc8_feed(crc_base, req_rx_byte);

   always_comb begin
      pos_in       = pos_ff;
      crc_in       = crc_ff;
      temp_ok_in   = temp_ok_ff;
      temp_word_in = temp_word_ff;
      hum_high_in  = hum_high_ff;
      hum_word_in  = hum_word_ff;
      emit         = 1'b0;
      item_in      = item_ff;
      if (accept) begin
         pos_in = (pos == POS_HUM_CRC) ? POS_TEMP_HIGH : pos_type'(pos + 3'd1);
         case (pos)
            POS_TEMP_HIGH: begin
               crc_in             = crc_new;
               temp_word_in[15:8] = req_rx_byte;
            end
            POS_TEMP_LOW: begin
               crc_in            = crc_new;
               temp_word_in[7:0] = req_rx_byte;
            end
            POS_TEMP_CRC: begin
               temp_ok_in = (crc_ff == req_rx_byte);
               crc_in     = htfd_pkg::CRC_INIT;
            end
            POS_HUM_HIGH: begin
               hum_high_in = req_rx_byte;
               crc_in      = crc_new;
            end
            POS_HUM_LOW: begin
               crc_in      = crc_new;
               hum_word_in = {hum_high_ff, req_rx_byte};
            end
            POS_HUM_CRC: begin
               emit              = 1'b1;
               crc_in            = htfd_pkg::CRC_INIT;
               item_in.temp_word = temp_word_ff;
               item_in.hum_word  = hum_word_ff;
               if (!temp_ok_ff) begin
                  item_in.status = htfd_pkg::STATUS_TEMP_CRC;
               end else if (crc_ff != req_rx_byte) begin
                  item_in.status = htfd_pkg::STATUS_HUM_CRC;
               end else begin
                  item_in.status = htfd_pkg::STATUS_OK;
               end
            end
            default: begin
               pos_in = POS_TEMP_HIGH;
            end
         endcase
      end
      if (emit) begin
         item_valid_in = 1'b1;
      end else if (item_ready) begin
         item_valid_in = 1'b0;
      end else begin
         item_valid_in = item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= POS_TEMP_HIGH;
         crc_ff        <= htfd_pkg::CRC_INIT;
         temp_ok_ff    <= 1'b0;
         item_valid_ff <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         crc_ff        <= crc_in;
         temp_ok_ff    <= temp_ok_in;
         item_valid_ff <= item_valid_in;
      end
      temp_word_ff <= temp_word_in;
      hum_high_ff  <= hum_high_in;
      hum_word_ff  <= hum_word_in;
      item_ff      <= item_in;
   end

   assign item_valid = item_valid_ff;
   assign item       = item_ff;

endmodule

FILE: rtl/core/htfd_conv.sv
// Conversion pipeline: scales the raw words (product stage), divides by
// full scale and applies the offset into the result register. Depends on htfd_pkg.
module htfd_conv (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     item_valid,
   output logic                     item_ready,
   input  htfd_pkg::frame_item_type item,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_status,
   output logic signed [11:0]       rsp_temperature,
   output logic [9:0]               rsp_humidity
);

   logic        prod_valid_ff, prod_valid_in;
   logic [1:0]  prod_status_ff;
   logic [26:0] prod_t_ff;
   logic [25:0] prod_h_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff;
   logic [11:0] rsp_temp_ff, rsp_temp_in;
   logic [9:0]  rsp_hum_ff, rsp_hum_in;
   logic        out_ready, prod_ready, prod_load, out_load;
   logic [16:0] sum_t, sum_h;
   logic [10:0] quot_t;
   logic [9:0]  quot_h;

   assign out_ready  = !rsp_valid_ff || !rsp_stall;
   assign prod_ready = !prod_valid_ff || out_ready;
   assign item_ready = prod_ready;
   assign prod_load  = item_valid && prod_ready;
   assign out_load   = prod_valid_ff && out_ready;

   assign prod_valid_in = prod_load ? 1'b1 : (out_ready ? 1'b0 : prod_valid_ff);
   assign rsp_valid_in  = out_load ? 1'b1 : (!rsp_stall ? 1'b0 : rsp_valid_ff);

   // x / 65535 with x = a*65536 + b equals a, plus one when a + b reaches 65535
   assign sum_t  = {6'd0, prod_t_ff[26:16]} + {1'b0, prod_t_ff[15:0]};
   assign sum_h  = {7'd0, prod_h_ff[25:16]} + {1'b0, prod_h_ff[15:0]};
   assign quot_t = prod_t_ff[26:16] + {10'd0, (sum_t >= htfd_pkg::FULL_SCALE)};
   assign quot_h = prod_h_ff[25:16] + {9'd0, (sum_h >= htfd_pkg::FULL_SCALE)};

   always_comb begin
      if (prod_status_ff == htfd_pkg::STATUS_OK) begin
         rsp_temp_in = {1'b0, quot_t} - htfd_pkg::TEMP_OFFSET;
         rsp_hum_in  = quot_h;
      end else begin
         rsp_temp_in = 12'd0;
         rsp_hum_in  = 10'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      if (prod_load) begin
         prod_status_ff <= item.status;
         prod_t_ff      <= 27'(htfd_pkg::TEMP_SCALE) * 27'(item.temp_word);
         prod_h_ff      <= 26'(htfd_pkg::HUM_SCALE) * 26'(item.hum_word);
      end
      if (out_load) begin
         rsp_status_ff <= prod_status_ff;
         rsp_temp_ff   <= rsp_temp_in;
         rsp_hum_ff    <= rsp_hum_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_temperature = $signed(rsp_temp_ff);
   assign rsp_humidity    = rsp_hum_ff;

endmodule

FILE: rtl/core/humidity_temp_frame_decoder.sv
// Top level of the humidity and temperature frame decoder.
// Instantiates htfd_frame and htfd_conv; depends on htfd_pkg.
//
// Usage:
//   Feed the six bytes of a sensor frame on the req_ channel, one item per
//   accepted cycle: temperature high, low, CRC, then humidity high, low, CRC.
//   Raise req_frame_first with the first byte of a frame to realign; a partial
//   frame is then dropped without a result. Without the flag, frames may
//   follow one another back to back.
//   After the sixth byte one item appears on the rsp_ channel: status (ok,
//   temperature CRC error, humidity CRC error), temperature in tenths of a
//   degree and humidity in tenths of a percent, both zero on any CRC error.
//   The result passes from the frame register, loaded at the edge that accepts
//   the sixth byte, through the product register into the result register.
//   Throughput: one byte per cycle while req_stall is low; each pipeline stage
//   holds one frame item.
//   Stall: while rsp_stall holds a result, bytes keep being accepted until
//   the pipeline behind the result register is full; only then is req_stall
//   raised, and only for the time the result side stays stalled.
//   Reset (synchronous, active high) clears the byte position, the CRC and all
//   valid flags; no result is pending afterwards.
module humidity_temp_frame_decoder (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   input  logic               req_frame_first,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic signed [11:0] rsp_temperature,
   output logic [9:0]         rsp_humidity
);

   // frame item handed from the byte tracker to the conversion pipeline
   logic                     item_valid;
   logic                     item_ready;
   htfd_pkg::frame_item_type item;

   // track byte position, run the CRC, build one item per frame
   htfd_frame u_frame (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .req_frame_first (req_frame_first),
      .item_valid      (item_valid),
      .item_ready      (item_ready),
      .item            (item)
   );

   // scale, divide by full scale, offset and hold the result
   htfd_conv u_conv (
      .clock           (clock),
      .reset           (reset),
      .item_valid      (item_valid),
      .item_ready      (item_ready),
      .item            (item),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_temperature (rsp_temperature),
      .rsp_humidity    (rsp_humidity)
   );

endmodule

FILE: rtl/core/htfd_checker.sv
// Port-level checks on the result channel of the frame decoder, and the bind
// that attaches them to humidity_temp_frame_decoder. Depends on htfd_pkg.
module htfd_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [1:0]         rsp_status,
   input logic signed [11:0] rsp_temperature,
   input logic [9:0]         rsp_humidity
);

   // a stalled result stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_temperature) && $stable(rsp_humidity))
      else $error("stalled result changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == htfd_pkg::STATUS_OK
         || rsp_status == htfd_pkg::STATUS_TEMP_CRC
         || rsp_status == htfd_pkg::STATUS_HUM_CRC)
      else $error("undefined status code");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != htfd_pkg::STATUS_OK
         |-> rsp_temperature == 12'sd0 && rsp_humidity == 10'd0)
      else $error("measurement not cleared on CRC error");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == htfd_pkg::STATUS_OK
         |-> rsp_humidity <= 10'd1000 && rsp_temperature >= -12'sd450
         && rsp_temperature <= 12'sd1300)
      else $error("converted value out of range");

endmodule

bind humidity_temp_frame_decoder htfd_checker u_htfd_checker (.*);
